// ===== sv/hre_pkg.sv =====
package hre_pkg;

	localparam int RECORD_DEPTH_DEF = 32;
	localparam int CFG_W = 6;
	localparam logic [CFG_W-1:0] MAX_RECORD_RESET = 6'd32;

	localparam int OP_W = 2;
	typedef enum logic [OP_W-1:0] {
		OP_DATA = 2'd0,
		OP_END = 2'd1,
		OP_START = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] TYPE_DATA = 8'h00;
	localparam logic [7:0] TYPE_EOF = 8'h01;

	// byte source of the current microcode step
	typedef enum logic [2:0] {
		SRC_COUNT,
		SRC_ADDR_HI,
		SRC_ADDR_LO,
		SRC_TYPE,
		SRC_DATA,
		SRC_CSUM
	} src_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_IF_DONE
	} jmp_t;

	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_COUNT = 3'd0;
	localparam logic [PC_W-1:0] PC_ADDR_HI = 3'd1;
	localparam logic [PC_W-1:0] PC_ADDR_LO = 3'd2;
	localparam logic [PC_W-1:0] PC_TYPE = 3'd3;
	localparam logic [PC_W-1:0] PC_LOAD = 3'd4;
	localparam logic [PC_W-1:0] PC_DATA = 3'd5;
	localparam logic [PC_W-1:0] PC_CSUM = 3'd6;
	localparam logic [PC_W-1:0] PC_NL = 3'd7;

	typedef struct packed {
		logic emit;
		logic colon;
		logic newline;
		src_t src;
		logic add_sum;
		logic idx_inc;
		jmp_t jmp;
		logic [PC_W-1:0] target;
		logic stop;
	} ucode_t;

	// Record program: header bytes, data loop (load then emit), checksum, newline.
	function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{emit: 1'b0, colon: 1'b0, newline: 1'b0, src: SRC_COUNT, add_sum: 1'b0,
			idx_inc: 1'b0, jmp: JMP_NEXT, target: PC_COUNT, stop: 1'b0};
		unique case (pc)
			PC_COUNT: begin
				w.emit = 1'b1; w.colon = 1'b1; w.src = SRC_COUNT; w.add_sum = 1'b1;
			end
			PC_ADDR_HI: begin
				w.emit = 1'b1; w.src = SRC_ADDR_HI; w.add_sum = 1'b1;
			end
			PC_ADDR_LO: begin
				w.emit = 1'b1; w.src = SRC_ADDR_LO; w.add_sum = 1'b1;
			end
			PC_TYPE: begin
				w.emit = 1'b1; w.src = SRC_TYPE; w.add_sum = 1'b1;
			end
			PC_LOAD: begin
				w.jmp = JMP_IF_DONE; w.target = PC_CSUM;
			end
			PC_DATA: begin
				w.emit = 1'b1; w.src = SRC_DATA; w.add_sum = 1'b1; w.idx_inc = 1'b1;
				w.jmp = JMP_ALWAYS; w.target = PC_LOAD;
			end
			PC_CSUM: begin
				w.emit = 1'b1; w.src = SRC_CSUM;
			end
			PC_NL: begin
				w.emit = 1'b1; w.newline = 1'b1; w.src = SRC_CSUM; w.stop = 1'b1;
			end
			default: begin
				w.stop = 1'b1;
			end
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
	endfunction

endpackage

// ===== sv/hex_record_encoder.sv =====
// Channel  Dir  Handshake              Payload
// s        in   s_tvalid / s_tready    s_tdata, s_tuser (op), s_tlast (span_last)
// m        out  m_tvalid / m_tready    m_tdata (two ASCII chars), m_tlast (record end)
// cfg      in   cfg_valid / cfg_ready  cfg_data (max_record_bytes)
//
// A data byte that does not close a record is only stored and counted. For a
// record of n data bytes, after its closing item, the sequencer runs one load
// and one emit step per data byte (set by the registered buffer read), so 6+n pairs
// come out at up to one per cycle. Reset clears the byte count, both addresses
// and sets the record limit to 32. A low m_tready holds the sequencer on the
// next emitting step; s_tready stays low while a record is being sent.
module hex_record_encoder #(
	parameter int RECORD_DEPTH = hre_pkg::RECORD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [7:0] data_byte, [8] span_first, [24:9] span_addr, [40:25] start_addr
	input  logic [47:0] s_tdata,
	// [1:0] op
	input  logic [hre_pkg::OP_W-1:0] s_tuser,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// [7:0] char_first, [15:8] char_second
	output logic [15:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [hre_pkg::CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(RECORD_DEPTH + 1);
	localparam int AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int LW = (CW > hre_pkg::CFG_W) ? CW : hre_pkg::CFG_W;

	// input fields
	logic [7:0] data_byte;
	logic span_first;
	logic [15:0] span_addr;
	logic [15:0] start_addr;
	hre_pkg::op_t op;

	assign data_byte = s_tdata[7:0];
	assign span_first = s_tdata[8];
	assign span_addr = s_tdata[24:9];
	assign start_addr = s_tdata[40:25];
	assign op = hre_pkg::op_t'(s_tuser);

	// collection state
	logic [7:0] buf_mem [RECORD_DEPTH];
	logic [7:0] rd_data_q;
	logic [CW-1:0] count_q;
	logic [15:0] rec_addr_q;
	logic [15:0] run_addr_q;
	logic [hre_pkg::CFG_W-1:0] max_q;

	// latched record header and sequencer
	logic busy_q;
	logic [hre_pkg::PC_W-1:0] pc_q;
	logic [CW-1:0] rec_count_q;
	logic [15:0] out_addr_q;
	logic [7:0] out_type_q;
	logic [CW-1:0] idx_q;
	logic [7:0] sum_q;
	logic [7:0] prev_q;

	// output register
	logic m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic m_tlast_q;

	logic s_acc;
	logic [CW-1:0] cnt_eff;
	logic [15:0] base_addr;
	logic [15:0] rec_addr_new;
	logic [CW-1:0] cnt_new;
	logic [CW-1:0] limit;
	logic flush;

	hre_pkg::ucode_t uw;
	logic advance;
	logic [7:0] cur;

	assign s_tready = !busy_q;
	assign s_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

	// Clamp the configured record length into 1..RECORD_DEPTH.
	always_comb begin
		if (max_q == '0) begin
			limit = CW'(1);
		end else if (LW'(max_q) > LW'(RECORD_DEPTH)) begin
			limit = CW'(RECORD_DEPTH);
		end else begin
			limit = CW'(max_q);
		end
	end

	// A new span restarts the count and the running address.
	assign cnt_eff = span_first ? '0 : count_q;
	assign base_addr = span_first ? span_addr : run_addr_q;
	assign rec_addr_new = (cnt_eff == '0) ? base_addr : rec_addr_q;
	assign cnt_new = cnt_eff + CW'(1);
	assign flush = s_tlast || (cnt_new >= limit);

	assign uw = hre_pkg::ucode_rom(pc_q);
	assign advance = busy_q && (!uw.emit || !m_tvalid_q || m_tready);

	always_comb begin
		case (uw.src)
			hre_pkg::SRC_COUNT: cur = 8'(rec_count_q);
			hre_pkg::SRC_ADDR_HI: cur = out_addr_q[15:8];
			hre_pkg::SRC_ADDR_LO: cur = out_addr_q[7:0];
			hre_pkg::SRC_TYPE: cur = out_type_q;
			hre_pkg::SRC_DATA: cur = rd_data_q;
			default: cur = 8'd0 - sum_q;
		endcase
	end

	// Buffer: write on data byte, registered read at the sequencer index.
	always_ff @(posedge clk) begin
		if (s_acc && op == hre_pkg::OP_DATA) begin
			buf_mem[cnt_eff[AW-1:0]] <= data_byte;
		end
		rd_data_q <= buf_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= hre_pkg::MAX_RECORD_RESET;
			count_q <= '0;
			rec_addr_q <= '0;
			run_addr_q <= '0;
			busy_q <= 1'b0;
			pc_q <= hre_pkg::PC_COUNT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end

			// load the output on an emit step, else drop it once taken
			if (advance && uw.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (s_acc) begin
				unique case (op)
					hre_pkg::OP_DATA: begin
						rec_addr_q <= rec_addr_new;
						run_addr_q <= base_addr + 16'd1;
						count_q <= flush ? '0 : cnt_new;
						if (flush) begin
							busy_q <= 1'b1;
							pc_q <= hre_pkg::PC_COUNT;
						end
					end
					hre_pkg::OP_END, hre_pkg::OP_START: begin
						count_q <= '0;
						busy_q <= 1'b1;
						pc_q <= hre_pkg::PC_COUNT;
					end
					default: begin
					end
				endcase
			end

			if (advance) begin
				if (uw.stop) begin
					busy_q <= 1'b0;
				end
				case (uw.jmp)
					hre_pkg::JMP_ALWAYS: pc_q <= uw.target;
					hre_pkg::JMP_IF_DONE: pc_q <= (idx_q == rec_count_q) ? uw.target
						: pc_q + hre_pkg::PC_W'(1);
					default: pc_q <= pc_q + hre_pkg::PC_W'(1);
				endcase
			end
		end
	end

	// Datapath registers: header latch, index, checksum, pair assembly.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			idx_q <= '0;
			sum_q <= '0;
			if (op == hre_pkg::OP_DATA) begin
				rec_count_q <= cnt_new;
				out_addr_q <= rec_addr_new;
				out_type_q <= hre_pkg::TYPE_DATA;
			end else begin
				rec_count_q <= '0;
				out_addr_q <= (op == hre_pkg::OP_START) ? start_addr : 16'd0;
				out_type_q <= hre_pkg::TYPE_EOF;
			end
		end
		if (advance) begin
			if (uw.emit) begin
				m_tdata_q[7:0] <= uw.colon ? hre_pkg::CHAR_COLON : hre_pkg::hex_char(prev_q[3:0]);
				m_tdata_q[15:8] <= uw.newline ? hre_pkg::CHAR_NL : hre_pkg::hex_char(cur[7:4]);
				m_tlast_q <= uw.newline;
				prev_q <= cur;
			end
			if (uw.add_sum) begin
				sum_q <= sum_q + cur;
			end
			if (uw.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

endmodule
